[hw/rtl/psr_pkg.sv]
// Shared constants, types and helper functions of the PID step rate controller.
`default_nettype none
package psr_pkg;

	localparam int ANGLE_WIDTH_DEF    = 17;
	localparam int INTEGRAL_WIDTH_DEF = 40;
	localparam int DRIVE_LIMIT_DEF    = 102400;

	localparam int CFG_DATA_W  = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int GAIN_W      = 24;
	localparam int SCALE_W     = 32;

	localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 24'd655360;
	localparam logic [GAIN_W-1:0]  GAIN_I_RST     = 24'd7;
	localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 24'd327680;
	localparam logic [SCALE_W-1:0] STEP_SCALE_RST = 32'd25600000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET, REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_STEP_SCALE
	} reg_index_t;

	// Work queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;

	// Operands of the multiplier are 64-bit magnitudes taken in 32-bit chunks.
	localparam int OPER_W  = 64;
	localparam int CHUNK_W = 32;
	localparam int PART_W  = GAIN_W + CHUNK_W;
	localparam int PROD_W  = GAIN_W + OPER_W;

	// Every product term saturates at this magnitude.
	localparam logic [OPER_W-1:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

	typedef struct packed {
		logic [GAIN_W-1:0]  gain_p;
		logic [GAIN_W-1:0]  gain_i;
		logic [GAIN_W-1:0]  gain_d;
		logic [SCALE_W-1:0] step_scale;
	} psr_cfg_t;

	function automatic logic [OPER_W-1:0] mag64(input logic [OPER_W-1:0] x);
		logic [OPER_W-1:0] r;
		r = x[OPER_W-1] ? (~x + 64'd1) : x;
		return r;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/psr_queue.sv]
// Small first-in first-out queue between the front and the back.
`default_nettype none
module psr_queue import psr_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  q_full,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !wr_en || rd_en)
		else $error("queue written while full");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty)
		else $error("queue read while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

[hw/rtl/psr_front.sv]
// Front part: takes angle requests, forms error, integral and derivative.
`default_nettype none
module psr_front import psr_pkg::*; #(
	parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
	parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
	localparam int ITEM_W = (ANGLE_WIDTH + 1) + (ANGLE_WIDTH + 2) + INTEGRAL_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [ANGLE_WIDTH-1:0] target_angle,
	input  wire logic signed [ANGLE_WIDTH-1:0] roll_angle,
	input  wire logic                          push,
	input  wire logic                          queue_full,
	output logic                               queue_wr,
	output logic [ITEM_W-1:0]                  queue_data
);

	localparam int ERR_W  = ANGLE_WIDTH + 1;
	localparam int DIFF_W = ANGLE_WIDTH + 2;
	localparam int IW     = INTEGRAL_WIDTH;
	localparam int SUM_W  = ((IW > ERR_W) ? IW : ERR_W) + 1;

	localparam logic signed [IW-1:0] ISUM_MAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] ISUM_MIN = {1'b1, {(IW-1){1'b0}}};

	logic signed [IW-1:0]     isum_q;
	logic signed [ERR_W-1:0]  prev_err_q;
	logic signed [ERR_W-1:0]  err;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SUM_W-1:0]  raw_sum;
	logic signed [IW-1:0]     isum_next;

	always_comb begin
		err     = ERR_W'(target_angle) - ERR_W'(roll_angle);
		diff    = DIFF_W'(err) - DIFF_W'(prev_err_q);
		raw_sum = SUM_W'(isum_q) + SUM_W'(err);
		if (raw_sum > SUM_W'(ISUM_MAX)) begin
			isum_next = ISUM_MAX;
		end else if (raw_sum < SUM_W'(ISUM_MIN)) begin
			isum_next = ISUM_MIN;
		end else begin
			isum_next = raw_sum[IW-1:0];
		end
	end

	assign queue_wr   = push && !queue_full;
	assign queue_data = {err, diff, isum_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			isum_q     <= '0;
			prev_err_q <= '0;
		end else if (queue_wr) begin
			isum_q     <= isum_next;
			prev_err_q <= err;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/psr_back.sv]
// Back part: gain products, clamp and rounding, deadband and step period divide.
`default_nettype none
module psr_back import psr_pkg::*; #(
	parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
	parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
	parameter int DRIVE_LIMIT    = DRIVE_LIMIT_DEF,
	localparam int ITEM_W  = (ANGLE_WIDTH + 1) + (ANGLE_WIDTH + 2) + INTEGRAL_WIDTH,
	localparam int DMAG_W  = $clog2(DRIVE_LIMIT + 1),
	localparam int DRIVE_W = DMAG_W + 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire psr_cfg_t             cfg,
	input  wire logic                 queue_empty,
	input  wire logic [ITEM_W-1:0]    queue_data,
	output logic                      queue_rd,
	output logic signed [DRIVE_W-1:0] drive,
	output logic                      direction,
	output logic                      halt,
	output logic [SCALE_W-1:0]        step_period,
	output logic                      empty,
	input  wire logic                 pop
);

	localparam int ERR_W  = ANGLE_WIDTH + 1;
	localparam int DIFF_W = ANGLE_WIDTH + 2;
	localparam int IW     = INTEGRAL_WIDTH;
	localparam int HALT_W = ((DMAG_W + 9) > GAIN_W) ? (DMAG_W + 9) : GAIN_W;
	localparam int DIV_CNT_W = $clog2(SCALE_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SCALE_W - 1);
	localparam logic [OPER_W-1:0] SUM_LIMIT = OPER_W'(DRIVE_LIMIT) << 16;
	localparam logic [OPER_W-1:0] ROUND_HALF = 64'h8000;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_MUL, S_ACC, S_TERM, S_MAG, S_RND, S_DIV, S_FIN
	} state_t;

	typedef enum logic [1:0] {TERM_P, TERM_D, TERM_I} term_t;

	state_t state_q;
	term_t  term_q;
	logic   chunk_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic   out_valid_q;

	logic signed [ERR_W-1:0]  err_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [IW-1:0]     isum_q;
	logic [OPER_W-1:0] mag_q;
	logic              neg_q;
	logic [GAIN_W-1:0] gain_q;
	logic [PART_W-1:0] part_q;
	logic [PROD_W-1:0] prod_q;
	logic signed [OPER_W-1:0] sum_q;
	logic [OPER_W-1:0] smag_q;
	logic              sneg_q;
	logic              dir_q;
	logic [DMAG_W-1:0] dmag_q;
	logic              hlt_q;
	logic [SCALE_W-1:0] quot_q;
	logic [DMAG_W-1:0]  rem_q;

	logic [OPER_W-1:0] oper;
	logic [GAIN_W-1:0] oper_gain;
	logic [OPER_W-1:0] term_mag;
	logic [OPER_W-1:0] clamped;
	logic [OPER_W-1:0] rounded;
	logic [DMAG_W-1:0] dmag_next;
	logic              halt_next;
	logic [DMAG_W:0]   trial;
	logic              trial_ge;
	logic              out_load;

	assign queue_rd = (state_q == S_IDLE) && !queue_empty;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;

	always_comb begin
		case (term_q)
			TERM_P: begin
				oper      = OPER_W'(err_q);
				oper_gain = cfg.gain_p;
			end
			TERM_D: begin
				oper      = OPER_W'(diff_q);
				oper_gain = cfg.gain_d;
			end
			TERM_I: begin
				oper      = OPER_W'(isum_q);
				oper_gain = cfg.gain_i;
			end
			default: begin
				oper      = '0;
				oper_gain = '0;
			end
		endcase

		term_mag = (prod_q > PROD_W'(TERM_LIMIT)) ? TERM_LIMIT : prod_q[OPER_W-1:0];

		clamped   = (smag_q > SUM_LIMIT) ? SUM_LIMIT : smag_q;
		rounded   = clamped + ROUND_HALF;
		dmag_next = rounded[16 +: DMAG_W];
		// Deadband: the drive is zero or, in degrees, below half the proportional gain.
		halt_next = (dmag_next == '0) ||
			(HALT_W'({dmag_next, 9'b0}) < HALT_W'(cfg.gain_p));

		trial    = {rem_q, quot_q[SCALE_W-1]};
		trial_ge = (trial >= {1'b0, dmag_q});
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (queue_rd) begin
					{err_q, diff_q, isum_q} <= queue_data;
				end
				sum_q <= '0;
			end
			S_LOAD: begin
				mag_q  <= mag64(oper);
				neg_q  <= oper[OPER_W-1];
				gain_q <= oper_gain;
			end
			S_MUL: begin
				part_q <= PART_W'(gain_q) *
					PART_W'(chunk_q ? mag_q[OPER_W-1:CHUNK_W] : mag_q[CHUNK_W-1:0]);
			end
			S_ACC: begin
				prod_q <= chunk_q ? (prod_q + (PROD_W'(part_q) << CHUNK_W)) :
					PROD_W'(part_q);
			end
			S_TERM: begin
				sum_q <= neg_q ? (sum_q - signed'(term_mag)) : (sum_q + signed'(term_mag));
			end
			S_MAG: begin
				smag_q <= mag64(sum_q);
				sneg_q <= sum_q[OPER_W-1];
				dir_q  <= !sum_q[OPER_W-1] && (sum_q != '0);
			end
			S_RND: begin
				dmag_q <= dmag_next;
				hlt_q  <= halt_next;
				quot_q <= cfg.step_scale;
				rem_q  <= '0;
			end
			S_DIV: begin
				// Restoring division, one quotient bit per cycle.
				rem_q  <= trial_ge ? DMAG_W'(trial - {1'b0, dmag_q}) : trial[DMAG_W-1:0];
				quot_q <= {quot_q[SCALE_W-2:0], trial_ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= TERM_P;
			chunk_q     <= 1'b0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
			drive       <= '0;
			direction   <= 1'b0;
			halt        <= 1'b0;
			step_period <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				drive       <= sneg_q ? -signed'(DRIVE_W'(dmag_q)) : signed'(DRIVE_W'(dmag_q));
				direction   <= dir_q;
				halt        <= hlt_q;
				step_period <= hlt_q ? '0 : quot_q;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (queue_rd) begin
						term_q  <= TERM_P;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					chunk_q <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (!chunk_q) begin
						chunk_q <= 1'b1;
						state_q <= S_MUL;
					end else begin
						state_q <= S_TERM;
					end
				end
				S_TERM: begin
					case (term_q)
						TERM_P: begin
							term_q  <= TERM_D;
							state_q <= S_LOAD;
						end
						TERM_D: begin
							term_q  <= TERM_I;
							state_q <= S_LOAD;
						end
						default: state_q <= S_MAG;
					endcase
				end
				S_MAG: state_q <= S_RND;
				S_RND: begin
					div_cnt_q <= '0;
					state_q   <= halt_next ? S_FIN : S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DIV_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> dmag_q != '0)
		else $error("divide started with zero drive magnitude");

	a_halt_period: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && halt |-> step_period == '0)
		else $error("halted result carries a step period");

	a_drive_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (drive <= DRIVE_LIMIT) && (drive >= -DRIVE_LIMIT))
		else $error("drive beyond its limit");

endmodule
`default_nettype wire

[hw/rtl/pid_step_rate_controller_core.sv]
// PID roll controller with clamp, deadband and step period: top level.
//
// Angle requests enter through push/full: one request is taken at each edge
// with push high and full low. Results leave through empty/pop: the oldest
// result sits on drive, direction, halt and step_period while empty is low and
// is taken at an edge with pop high. Gains, set point and step scale are
// written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user must
// write them only while the block is idle, which the block does not enforce.
// cfg_ready is always high and unknown indexes are dropped. The front
// computes error, integral and derivative in the cycle a request is taken
// and hands it to a two-entry queue, so up to two requests are held while
// the back works or while a result waits. The back works on one request
// at a time: three gain products through one 24x32 multiplier in two
// chunks each, then a restoring divide for the step period, skipped when
// the result is halted. It takes a new request from the queue only once it
// is idle again. When pop stays low the finished result is held, the back
// then stalls, and full rises once the queue fills. Reset empties the
// queue, clears integral and last error and loads the default register
// values.
`default_nettype none
module pid_step_rate_controller_core import psr_pkg::*; #(
	parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
	parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
	parameter int DRIVE_LIMIT    = DRIVE_LIMIT_DEF,
	localparam int DRIVE_W = $clog2(DRIVE_LIMIT + 1) + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [ANGLE_WIDTH-1:0] roll_angle,
	output logic                               empty,
	input  wire logic                          pop,
	output logic signed [DRIVE_W-1:0]          drive,
	output logic                               direction,
	output logic                               halt,
	output logic [SCALE_W-1:0]                 step_period,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
	input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

	localparam int ITEM_W = (ANGLE_WIDTH + 1) + (ANGLE_WIDTH + 2) + INTEGRAL_WIDTH;

	psr_cfg_t                      cfg_q;
	logic signed [ANGLE_WIDTH-1:0] target_angle_q;
	logic                          queue_wr;
	logic                          queue_rd;
	logic                          queue_full;
	logic                          queue_empty;
	logic [ITEM_W-1:0]             queue_wdata;
	logic [ITEM_W-1:0]             queue_rdata;

	assign cfg_ready = 1'b1;
	assign full      = queue_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_angle_q   <= '0;
			cfg_q.gain_p     <= GAIN_P_RST;
			cfg_q.gain_i     <= GAIN_I_RST;
			cfg_q.gain_d     <= GAIN_D_RST;
			cfg_q.step_scale <= STEP_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TARGET:     target_angle_q   <= cfg_data[ANGLE_WIDTH-1:0];
				REG_GAIN_P:     cfg_q.gain_p     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_I:     cfg_q.gain_i     <= cfg_data[GAIN_W-1:0];
				REG_GAIN_D:     cfg_q.gain_d     <= cfg_data[GAIN_W-1:0];
				REG_STEP_SCALE: cfg_q.step_scale <= cfg_data[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	psr_front #(
		.ANGLE_WIDTH    (ANGLE_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_angle (target_angle_q),
		.roll_angle   (roll_angle),
		.push         (push),
		.queue_full   (queue_full),
		.queue_wr     (queue_wr),
		.queue_data   (queue_wdata)
	);

	psr_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (queue_wr),
		.wr_data (queue_wdata),
		.q_full  (queue_full),
		.rd_en   (queue_rd),
		.rd_data (queue_rdata),
		.q_empty (queue_empty)
	);

	psr_back #(
		.ANGLE_WIDTH    (ANGLE_WIDTH),
		.INTEGRAL_WIDTH (INTEGRAL_WIDTH),
		.DRIVE_LIMIT    (DRIVE_LIMIT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.queue_empty (queue_empty),
		.queue_data  (queue_rdata),
		.queue_rd    (queue_rd),
		.drive       (drive),
		.direction   (direction),
		.halt        (halt),
		.step_period (step_period),
		.empty       (empty),
		.pop         (pop)
	);

endmodule
`default_nettype wire

[bench/pid_step_rate_controller_core_tb.sv]
// Self-checking testbench for the PID step rate controller core.
`timescale 1ns / 100ps
module pid_step_rate_controller_core_tb;
	import psr_pkg::*;

	localparam int ANGLE_W   = ANGLE_WIDTH_DEF;
	localparam int INT_W     = INTEGRAL_WIDTH_DEF;
	localparam int DRIVE_W   = $clog2(DRIVE_LIMIT_DEF + 1) + 1;
	localparam int ANGLE_MAX = 46080;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A    = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_C    = 3'd7;

	localparam longint TERM_CAP     = 64'sh2000_0000_0000_0000;
	localparam longint DRIVE_CLAMP  = longint'(DRIVE_LIMIT_DEF) << 16;
	localparam int     SETTLE_WAIT  = 64;
	localparam int     STALL_LIMIT  = 2000;
	localparam int     PHASE_ITEMS  = 100;
	localparam int     NOISY_PHASES = 6;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      direction;
		logic                      halt;
		logic [SCALE_W-1:0]        step_period;
	} ctrl_result_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      push       = 1'b0;
	logic                      full;
	logic signed [ANGLE_W-1:0] roll_angle = '0;
	logic                      empty;
	logic                      pop        = 1'b0;
	logic signed [DRIVE_W-1:0] drive;
	logic                      direction;
	logic                      halt;
	logic [SCALE_W-1:0]        step_period;
	logic                      cfg_valid  = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_W-1:0]    cfg_index  = '0;
	logic [CFG_DATA_W-1:0]     cfg_data   = '0;

	// Shadow copy of the registers and the controller state.
	logic signed [ANGLE_W-1:0] sp_shadow    = '0;
	logic [GAIN_W-1:0]         gp_shadow    = GAIN_P_RST;
	logic [GAIN_W-1:0]         gi_shadow    = GAIN_I_RST;
	logic [GAIN_W-1:0]         gd_shadow    = GAIN_D_RST;
	logic [SCALE_W-1:0]        scale_shadow = STEP_SCALE_RST;
	longint                    err_sum      = 0;
	longint                    last_err     = 0;

	ctrl_result_t pending_drives[$];
	ctrl_result_t want;

	logic calm        = 1'b0;
	int   pop_stall   = 0;
	int   idle_cycles = 0;
	int   requests    = 0;
	int   results     = 0;
	int   reg_writes  = 0;
	int   settings    = 0;
	int   mismatches  = 0;

	pid_step_rate_controller_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.roll_angle  (roll_angle),
		.empty       (empty),
		.pop         (pop),
		.drive       (drive),
		.direction   (direction),
		.halt        (halt),
		.step_period (step_period),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic ctrl_result_t compute_drive(input logic signed [ANGLE_W-1:0] angle);
		longint sat_hi, e, d, gp, gi, gd, scale, isum_mag, iprod, sum, smag, dmag;
		ctrl_result_t r;
		sat_hi = (longint'(1) << (INT_W - 1)) - 1;
		gp = longint'(gp_shadow);
		gi = longint'(gi_shadow);
		gd = longint'(gd_shadow);
		scale = longint'(scale_shadow);
		e = longint'(sp_shadow) - longint'(angle);
		if (e > 0 && err_sum > sat_hi - e) begin
			err_sum = sat_hi;
		end else if (e < 0 && err_sum < -sat_hi - 1 - e) begin
			err_sum = -sat_hi - 1;
		end else begin
			err_sum = err_sum + e;
		end
		d = e - last_err;
		last_err = e;
		isum_mag = (err_sum < 0) ? -err_sum : err_sum;
		if (gi != 0 && isum_mag > TERM_CAP / gi)
			iprod = TERM_CAP;
		else
			iprod = isum_mag * gi;
		sum = gp * e + gd * d + ((err_sum < 0) ? -iprod : iprod);
		smag = (sum < 0) ? -sum : sum;
		if (smag > DRIVE_CLAMP)
			smag = DRIVE_CLAMP;
		// Round to whole drive units, ties away from zero.
		dmag = (smag + 64'sh8000) >> 16;
		r.drive = DRIVE_W'((sum < 0) ? -dmag : dmag);
		r.direction = (sum > 0);
		r.halt = (dmag == 0) || ((dmag << 9) < gp);
		r.step_period = r.halt ? '0 : SCALE_W'(scale / dmag);
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint exp_v, input longint got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch in %s at result %0d: expected %0d, got %0d",
				what, results, exp_v, got_v);
	endtask

	// Result side: random pop stalls and the field-by-field check.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				results++;
				if (pending_drives.size() == 0) begin
					flag_mismatch("unrequested result drive", 0, drive);
				end else begin
					want = pending_drives.pop_front();
					if (drive !== want.drive)
						flag_mismatch("drive", want.drive, drive);
					if (direction !== want.direction)
						flag_mismatch("direction", want.direction, direction);
					if (halt !== want.halt)
						flag_mismatch("halt", want.halt, halt);
					if (step_period !== want.step_period)
						flag_mismatch("step_period", want.step_period, step_period);
				end
			end
			if (pop_stall > 0) begin
				pop_stall <= pop_stall - 1;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				pop_stall <= $urandom_range(1, 11) - 1;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Ends the run when nothing has moved on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", idle_cycles);
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
		roll_angle <= angle;
		push <= 1'b1;
		do @(posedge clk); while (full);
		requests++;
		pending_drives.push_back(compute_drive(angle));
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Leaves cfg_valid high so that back-to-back writes need no toggle.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			REG_TARGET:     sp_shadow = data[ANGLE_W-1:0];
			REG_GAIN_P:     gp_shadow = data[GAIN_W-1:0];
			REG_GAIN_I:     gi_shadow = data[GAIN_W-1:0];
			REG_GAIN_D:     gd_shadow = data[GAIN_W-1:0];
			REG_STEP_SCALE: scale_shadow = data[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [31:0] sp, input logic [31:0] gp, input logic [31:0] gi,
		input logic [31:0] gd, input logic [31:0] scale);
		logic [CFG_INDEX_W-1:0] spare;
		case ($urandom_range(0, 2))
			0:       spare = REG_SPARE_A;
			1:       spare = REG_SPARE_B;
			default: spare = REG_SPARE_C;
		endcase
		write_reg(REG_TARGET, sp);
		write_reg(spare, $urandom);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_STEP_SCALE, scale);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Stops requests and waits until the block has gone quiet.
	task automatic settle();
		push <= 1'b0;
		while (pending_drives.size() != 0) @(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_gain();
		case ($urandom_range(0, 7))
			0:       return 32'd0;
			1:       return 32'h00FF_FFFF;
			2:       return $urandom;
			3:       return $urandom_range(0, 32'h0000_0400);
			default: return $urandom_range(0, 32'h000C_0000);
		endcase
	endfunction

	function automatic logic [31:0] rand_target();
		int v;
		case ($urandom_range(0, 5))
			0:       v = -ANGLE_MAX;
			1:       v = ANGLE_MAX;
			2:       v = $urandom;
			default: v = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
		endcase
		// Bits above the field carry noise that the block must drop.
		return ($urandom & ~32'h1_FFFF) | (v & 32'h1_FFFF);
	endfunction

	function automatic logic [31:0] rand_scale();
		case ($urandom_range(0, 7))
			0:       return 32'd0;
			1:       return 32'd1;
			2:       return 32'hFFFF_FFFF;
			3:       return $urandom;
			default: return $urandom_range(1_000_000, 60_000_000);
		endcase
	endfunction

	function automatic logic signed [ANGLE_W-1:0] rand_angle();
		int v;
		case ($urandom_range(0, 9))
			0:       v = $urandom;
			1:       v = ($urandom_range(0, 1) != 0) ? ANGLE_MAX : -ANGLE_MAX;
			2, 3:    v = int'(sp_shadow) + int'($urandom_range(0, 64)) - 32;
			default: v = int'($urandom_range(0, 2 * ANGLE_MAX)) - ANGLE_MAX;
		endcase
		return v[ANGLE_W-1:0];
	endfunction

	task automatic test_default_registers();
		send_angle(0);
		send_angle(ANGLE_W'(ANGLE_MAX));
		send_angle(ANGLE_W'(-ANGLE_MAX));
		send_angle(17'sh0FFFF);
		send_angle(17'sh10000);
		send_angle(1);
		send_angle(ANGLE_W'(-1));
		send_angle(0);
		settle();
	endtask

	task automatic test_deadband_and_rounding();
		// A sum of one LSB rounds to zero drive while direction still reads positive.
		load_settings(0, 1, 0, 0, STEP_SCALE_RST);
		send_angle(ANGLE_W'(-1));
		send_angle(1);
		send_angle(ANGLE_W'(-32768));
		send_angle(ANGLE_W'(32768));
		settle();
		// Without a proportional gain only a zero drive halts; a zero scale gives period zero.
		load_settings(0, 0, 0, 32'h0001_0000, 0);
		send_angle(ANGLE_W'(-256));
		send_angle(ANGLE_W'(-256));
		send_angle(0);
		settle();
	endtask

	task automatic test_register_extremes();
		load_settings(32'hA5A1_4C00, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF);
		send_angle(ANGLE_W'(ANGLE_MAX));
		send_angle(ANGLE_W'(-ANGLE_MAX));
		send_angle(0);
		send_angle(17'sh0FFFF);
		settle();
		load_settings(ANGLE_MAX, 32'hFF01_0000, 0, 0, 1);
		send_angle(17'sh10000);
		send_angle(ANGLE_W'(ANGLE_MAX));
		send_angle(ANGLE_W'(ANGLE_MAX - 1));
		settle();
	endtask

	task automatic run_random_phase();
		load_settings(rand_target(), rand_gain(), rand_gain(), rand_gain(), rand_scale());
		repeat (PHASE_ITEMS) send_angle(rand_angle());
		settle();
	endtask

	task automatic test_random_settings();
		repeat (NOISY_PHASES) run_random_phase();
	endtask

	task automatic test_full_rate();
		calm = 1'b1;
		run_random_phase();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_registers();
		test_deadband_and_rounding();
		test_register_extremes();
		test_random_settings();
		test_full_rate();
		$display("Covered %0d angle requests and %0d results under %0d register settings",
			requests, results, settings);
		$display("(%0d register writes, %0d mismatches)", reg_writes, mismatches);
		if (mismatches == 0 && pending_drives.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
